[hw/rtl/bcm_pkg.sv]
// Shared types, widths and helpers for the binary classification metrics core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package bcm_pkg;

	localparam int COUNT_BITS = 32;
	localparam int SCORE_BITS = 16;
	localparam int PCT_W      = 15;
	localparam int OUT_CNT_W  = 32;

	// Divisor holds the sum of four counters, or P+R for the F1 step.
	localparam int DEN_W = (COUNT_BITS + 2 > PCT_W + 2) ? COUNT_BITS + 2 : PCT_W + 2;
	// Dividend is below den * 2^PCT_W for every division in the core.
	localparam int NUM_W = DEN_W + PCT_W;
	localparam int EXT_W = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

	localparam logic [SCORE_BITS-1:0] THRESHOLD_RESET = SCORE_BITS'(128);

	localparam logic [1:0] TRUTH_NEG = 2'd0;
	localparam logic [1:0] TRUTH_POS = 2'd1;

	typedef struct packed {
		logic [SCORE_BITS-1:0] score;
		logic [1:0]            truth_code;
		logic                  last;
	} sample_t;

	typedef struct packed {
		logic [OUT_CNT_W-1:0] true_pos;
		logic [OUT_CNT_W-1:0] false_pos;
		logic [OUT_CNT_W-1:0] true_neg;
		logic [OUT_CNT_W-1:0] false_neg;
		logic [PCT_W-1:0]     accuracy_pct;
		logic [PCT_W-1:0]     precision_pct;
		logic [PCT_W-1:0]     recall_pct;
		logic [PCT_W-1:0]     f1_pct;
	} result_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] tp;
		logic [COUNT_BITS-1:0] fp;
		logic [COUNT_BITS-1:0] tn;
		logic [COUNT_BITS-1:0] fn;
	} counts_t;

	typedef struct packed {
		logic inc;
		logic clr;
	} cnt_ctl_t;

	// Zero-extend or truncate a counter to the result field width.
	function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [COUNT_BITS-1:0] c);
		logic [EXT_W-1:0] e;
		e = EXT_W'(c);
		return e[OUT_CNT_W-1:0];
	endfunction

	// num * 25600 as shifts and adds: 25600 = (64 + 32 + 4) * 256.
	function automatic logic [NUM_W-1:0] scale_pct(input logic [DEN_W-1:0] n);
		logic [NUM_W-1:0] e;
		e = NUM_W'(n);
		return (e << 14) + (e << 13) + (e << 10);
	endfunction

endpackage

[hw/rtl/bcm_counter.sv]
// Confusion matrix counters: classify one sample per cycle, saturate at full scale.
// Depends on bcm_pkg.
`timescale 1ns / 1ps

module bcm_counter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bcm_pkg::cnt_ctl_t              ctl,
	input  logic [bcm_pkg::SCORE_BITS-1:0] score,
	input  logic [1:0]                     truth_code,
	input  logic [bcm_pkg::SCORE_BITS-1:0] threshold,
	output bcm_pkg::counts_t               counts
);
	import bcm_pkg::*;

	counts_t cnt_q;
	logic    pos;

	assign pos    = $signed(score) >= $signed(threshold);
	assign counts = cnt_q;

	function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
		return (&c) ? c : c + COUNT_BITS'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clr) begin
			cnt_q <= '0;
		end else if (ctl.inc) begin
			// other truth codes count nowhere
			if (truth_code == TRUTH_POS) begin
				if (pos) cnt_q.tp <= bump(cnt_q.tp);
				else     cnt_q.fn <= bump(cnt_q.fn);
			end else if (truth_code == TRUTH_NEG) begin
				if (pos) cnt_q.fp <= bump(cnt_q.fp);
				else     cnt_q.tn <= bump(cnt_q.tn);
			end
		end
	end

endmodule

[hw/rtl/bcm_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle, PCT_W bits per run.
// Requires num < den * 2^PCT_W; a zero divisor gives a zero quotient. Depends on bcm_pkg.
`timescale 1ns / 1ps

module bcm_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bcm_pkg::NUM_W-1:0] num,
	input  logic [bcm_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [bcm_pkg::PCT_W-1:0] quot
);
	import bcm_pkg::*;

	localparam int CNT_W = $clog2(PCT_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PCT_W - 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [PCT_W-1:0] lo_q;
	logic [PCT_W-1:0] quo_q;
	logic             zero_q;
	logic [CNT_W-1:0] step_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, lo_q[PCT_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quot  = zero_q ? '0 : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + CNT_W'(1);
				if (step_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// upper part of the dividend is already below the divisor
			rem_q  <= num[NUM_W-1:PCT_W];
			lo_q   <= num[PCT_W-1:0];
			den_q  <= den;
			zero_q <= (den == '0);
			quo_q  <= '0;
		end else if (run_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			lo_q  <= {lo_q[PCT_W-2:0], 1'b0};
			quo_q <= {quo_q[PCT_W-2:0], fits};
		end
	end

endmodule

[hw/rtl/binary_classification_metrics_core.sv]
// Top level of the binary classification metrics core: threshold register,
// counters, end-of-batch sequencer and result register. Depends on bcm_pkg,
// bcm_counter and bcm_divider.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// sample    in         sample_valid/stall    sample_t: score, truth_code, last
// result    out        result_valid/stall    result_t: four counts, four percentages
// cfg       in         cfg_we                cfg_data: threshold
//
// Samples without last stream back to back.
// A last sample starts the end-of-batch pass: a snapshot state, then four divisions
// on the shared bit-serial divider (each a load state and a wait for done) and one
// multiply state ahead of the F1 division; sample_stall is high throughout the pass.
// The result waits in its register while result_stall is high; a following batch
// streams in meanwhile and its own end-of-batch pass holds before the result load.
// Reset clears the counters and sets the threshold to 0.5.

module binary_classification_metrics_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  bcm_pkg::sample_t               sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output bcm_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [bcm_pkg::SCORE_BITS-1:0] cfg_data
);
	import bcm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SNAP = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	localparam logic [1:0] OP_ACC  = 2'd0;
	localparam logic [1:0] OP_PREC = 2'd1;
	localparam logic [1:0] OP_REC  = 2'd2;
	localparam logic [1:0] OP_F1   = 2'd3;

	logic [2:0]            state_q;
	logic [1:0]            op_q;
	logic [SCORE_BITS-1:0] threshold_q;
	counts_t               snap_q;
	logic [PCT_W-1:0]      acc_q;
	logic [PCT_W-1:0]      prec_q;
	logic [PCT_W-1:0]      rec_q;
	logic [PCT_W-1:0]      f1_q;
	logic [2*PCT_W-1:0]    pr_q;
	logic [PCT_W:0]        psum_q;
	logic                  result_valid_q;
	result_t               result_q;

	counts_t               counts;
	cnt_ctl_t              cnt_ctl;
	logic                  accept;
	logic                  div_start;
	logic [NUM_W-1:0]      div_num;
	logic [DEN_W-1:0]      div_den;
	logic                  div_done;
	logic [PCT_W-1:0]      div_quot;
	logic                  slot_free;

	assign sample_stall = (state_q != S_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign cnt_ctl.inc  = accept;
	assign cnt_ctl.clr  = (state_q == S_SNAP);
	assign div_start    = (state_q == S_LOAD);
	assign slot_free    = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	bcm_counter u_counter (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (cnt_ctl),
		.score      (sample.score),
		.truth_code (sample.truth_code),
		.threshold  (threshold_q),
		.counts     (counts)
	);

	bcm_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// operand select for the shared divider
	always_comb begin
		unique case (op_q)
			OP_ACC: begin
				div_num = scale_pct(DEN_W'(snap_q.tp) + DEN_W'(snap_q.tn));
				div_den = DEN_W'(snap_q.tp) + DEN_W'(snap_q.fp)
					+ DEN_W'(snap_q.tn) + DEN_W'(snap_q.fn);
			end
			OP_PREC: begin
				div_num = scale_pct(DEN_W'(snap_q.tp));
				div_den = DEN_W'(snap_q.tp) + DEN_W'(snap_q.fp);
			end
			OP_REC: begin
				div_num = scale_pct(DEN_W'(snap_q.tp));
				div_den = DEN_W'(snap_q.tp) + DEN_W'(snap_q.fn);
			end
			OP_F1: begin
				div_num = NUM_W'({pr_q, 1'b0});
				div_den = DEN_W'(psum_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= OP_ACC;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && slot_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && sample.last) state_q <= S_SNAP;
				end
				S_SNAP: begin
					op_q    <= OP_ACC;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						unique case (op_q)
							OP_ACC, OP_PREC: begin
								op_q    <= op_q + 2'd1;
								state_q <= S_LOAD;
							end
							OP_REC:  state_q <= S_MUL;
							OP_F1:   state_q <= S_OUT;
						endcase
					end
				end
				S_MUL: begin
					op_q    <= OP_F1;
					state_q <= S_LOAD;
				end
				S_OUT: begin
					// hold until the result register is free
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SNAP) snap_q <= counts;
		if (state_q == S_WAIT && div_done) begin
			unique case (op_q)
				OP_ACC:  acc_q  <= div_quot;
				OP_PREC: prec_q <= div_quot;
				OP_REC:  rec_q  <= div_quot;
				OP_F1:   f1_q   <= div_quot;
			endcase
		end
		if (state_q == S_MUL) begin
			pr_q   <= prec_q * rec_q;
			psum_q <= {1'b0, prec_q} + {1'b0, rec_q};
		end
		if (state_q == S_OUT && slot_free) begin
			result_q.true_pos      <= cnt_out(snap_q.tp);
			result_q.false_pos     <= cnt_out(snap_q.fp);
			result_q.true_neg      <= cnt_out(snap_q.tn);
			result_q.false_neg     <= cnt_out(snap_q.fn);
			result_q.accuracy_pct  <= acc_q;
			result_q.precision_pct <= prec_q;
			result_q.recall_pct    <= rec_q;
			result_q.f1_pct        <= f1_q;
		end
	end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for binary_classification_metrics_core: random and directed
// batches of scored samples, with counts and Q7.8 percentages predicted and compared.
// Depends on bcm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

	import bcm_pkg::*;

	localparam int SETTLE_CYCLES  = 120;
	localparam int WATCHDOG_LIMIT = 4000;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	sample_t               sample       = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_we       = 1'b0;
	logic [SCORE_BITS-1:0] cfg_data     = '0;

	sample_t sample_queue[$];
	result_t metrics_due[$];

	// Predictor state
	logic [SCORE_BITS-1:0] thr_model = THRESHOLD_RESET;
	logic [COUNT_BITS-1:0] tp_cnt = '0, fp_cnt = '0, tn_cnt = '0, fn_cnt = '0;

	int  samples_queued = 0;
	int  samples_taken  = 0;
	int  error_count    = 0;
	int  send_gap       = 0;
	int  stall_left     = 0;
	int  quiet_cycles   = 0;
	bit  quiet_mode     = 1'b0;

	binary_classification_metrics_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// floor(25600 * num / den), zero on an empty divisor
	function automatic logic [PCT_W-1:0] percent_of(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		if (den == 0)
			return '0;
		q = (num * 64'd25600) / den;
		return q[PCT_W-1:0];
	endfunction

	function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	task automatic tally_sample(input sample_t s);
		result_t         m;
		longint unsigned tp, fp, tn, fn, p, r, sum;
		bit              pos;
		pos = $signed(s.score) >= $signed(thr_model);
		if (s.truth_code == TRUTH_POS) begin
			if (pos) tp_cnt = bump(tp_cnt); else fn_cnt = bump(fn_cnt);
		end else if (s.truth_code == TRUTH_NEG) begin
			if (pos) fp_cnt = bump(fp_cnt); else tn_cnt = bump(tn_cnt);
		end
		if (s.last) begin
			tp = tp_cnt;
			fp = fp_cnt;
			tn = tn_cnt;
			fn = fn_cnt;
			p = percent_of(tp, tp + fp);
			r = percent_of(tp, tp + fn);
			sum = p + r;
			m.true_pos      = tp_cnt;
			m.false_pos     = fp_cnt;
			m.true_neg      = tn_cnt;
			m.false_neg     = fn_cnt;
			m.accuracy_pct  = percent_of(tp + tn, tp + fp + tn + fn);
			m.precision_pct = p[PCT_W-1:0];
			m.recall_pct    = r[PCT_W-1:0];
			m.f1_pct        = (sum == 0) ? '0 : PCT_W'((2 * p * r) / sum);
			metrics_due.push_back(m);
			tp_cnt = '0;
			fp_cnt = '0;
			tn_cnt = '0;
			fn_cnt = '0;
		end
	endtask

	task automatic check_field(input string name, input longint unsigned got,
			input longint unsigned want);
		if (got != want)
			report_error($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (metrics_due.size() == 0) begin
			report_error("result with no batch outstanding");
			return;
		end
		want = metrics_due.pop_front();
		check_field("true_pos",      got.true_pos,      want.true_pos);
		check_field("false_pos",     got.false_pos,     want.false_pos);
		check_field("true_neg",      got.true_neg,      want.true_neg);
		check_field("false_neg",     got.false_neg,     want.false_neg);
		check_field("accuracy_pct",  got.accuracy_pct,  want.accuracy_pct);
		check_field("precision_pct", got.precision_pct, want.precision_pct);
		check_field("recall_pct",    got.recall_pct,    want.recall_pct);
		check_field("f1_pct",        got.f1_pct,        want.f1_pct);
	endtask

	// Sample driver: hold the request while stalled, insert random gaps after each one outside quiet mode
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (sample_valid && !sample_stall) begin
				tally_sample(sample);
				samples_taken++;
			end
			if (!(sample_valid && sample_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_valid <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					sample       <= sample_queue.pop_front();
					sample_valid <= 1'b1;
					send_gap = quiet_mode ? 0 : idle_len();
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure outside quiet mode
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_valid && !result_stall)
				check_result(result);
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if (!quiet_mode && $urandom_range(0, 7) == 0)
					stall_left = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			quiet_cycles = 0;
		end else if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic add_sample(input int sc, input int truth, input bit last);
		sample_t s;
		s.score      = sc[SCORE_BITS-1:0];
		s.truth_code = truth[1:0];
		s.last       = last;
		sample_queue.push_back(s);
		samples_queued++;
	endtask

	// Drain: every request taken, every batch reported, end-of-batch pass done
	task automatic settle();
		wait (samples_taken == samples_queued && metrics_due.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input int v);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v[SCORE_BITS-1:0];
		@(posedge clk);
		cfg_we   <= 1'b0;
		thr_model = v[SCORE_BITS-1:0];
	endtask

	function automatic int rand_score();
		int r, t;
		r = $urandom_range(0, 9);
		if (r == 0)
			return -32768;
		if (r == 1)
			return 32767;
		if (r < 5) begin
			// land on or within three of the threshold
			t = int'($signed(thr_model)) + $urandom_range(0, 6) - 3;
			if (t > 32767) t = 32767;
			if (t < -32768) t = -32768;
			return t;
		end
		return $urandom_range(0, 65535);
	endfunction

	function automatic int rand_truth();
		int r;
		r = $urandom_range(0, 19);
		if (r < 9)
			return TRUTH_NEG;
		if (r < 18)
			return TRUTH_POS;
		return (r == 18) ? 2 : 3;
	endfunction

	task automatic run_batches(input int n_items);
		int left, len, r;
		left = n_items;
		while (left > 0) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				len = $urandom_range(1, 8);
			else if (r < 90)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(41, 200);
			if (len > left)
				len = left;
			for (int i = 0; i < len; i++)
				add_sample(rand_score(), rand_truth(), i == len - 1);
			left -= len;
		end
	endtask

	initial begin
		int thr;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Threshold at its reset value
		add_sample(0, 2, 1);                // nothing counted, all divisors zero
		add_sample(128, TRUTH_POS, 1);      // score equal to threshold is positive
		add_sample(127, TRUTH_POS, 1);
		add_sample(128, TRUTH_NEG, 0);
		add_sample(127, TRUTH_NEG, 1);
		add_sample(32767, TRUTH_POS, 0);
		add_sample(-32768, TRUTH_NEG, 0);
		add_sample(32767, TRUTH_NEG, 0);
		add_sample(-32768, TRUTH_POS, 0);
		add_sample(0, 3, 0);
		add_sample(300, TRUTH_POS, 1);
		settle();

		quiet_mode = 1'b1;
		write_threshold(-32768);
		add_sample(-32768, TRUTH_POS, 0);
		add_sample(-32768, TRUTH_NEG, 0);
		add_sample(32767, TRUTH_POS, 1);
		add_sample(5, TRUTH_POS, 0);        // perfect batch: every metric full scale
		add_sample(6, TRUTH_POS, 1);
		settle();

		quiet_mode = 1'b0;
		write_threshold(32767);
		add_sample(32767, TRUTH_POS, 0);
		add_sample(32766, TRUTH_POS, 0);
		add_sample(32766, TRUTH_NEG, 1);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: thr = 0;
				1: thr = -32768;
				2: thr = 32767;
				default: thr = $urandom_range(0, 65535) - 32768;
			endcase
			quiet_mode = (ph == 3) || ($urandom_range(0, 4) == 0);
			write_threshold(thr);
			run_batches(100);
			// hold new requests until every batch so far is reported
			if (ph == 4)
				wait (samples_taken == samples_queued && metrics_due.size() == 0);
			run_batches(100);
			settle();
		end

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/bcm_pkg.sv
hw/rtl/bcm_counter.sv
hw/rtl/bcm_divider.sv
hw/rtl/binary_classification_metrics_core.sv
verif/tb_top.sv
